/* design/lndr_pkg.sv */
`timescale 1ns / 1ps

package lndr_pkg;

  // Default screen geometry
  localparam int SCREEN_WIDTH_DEF = 128;
  localparam int SCREEN_PAGES_DEF = 8;

  // Field widths of the command and response transactions
  localparam int OP_W    = 2;
  localparam int X_W     = 7;
  localparam int Y_W     = 6;
  localparam int MODE_W  = 2;
  localparam int COUNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PLOT = 2'd0,
    OP_LINE = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } lndr_op_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET    = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_INVERT = 2'd2,
    MODE_KEEP   = 2'd3
  } lndr_mode_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [X_W-1:0]    start_x;
    logic [Y_W-1:0]    start_y;
    logic [X_W-1:0]    end_x;
    logic [Y_W-1:0]    end_y;
    logic [MODE_W-1:0] pixel_mode;
  } lndr_cmd_t;

  typedef struct packed {
    logic               pixel_value;
    logic [COUNT_W-1:0] pixels_drawn;
  } lndr_rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture a command and its line geometry
    logic wrap;      // reduce the start point into the screen
    logic pix_rd;    // read the byte under the current point
    logic pix_wr;    // write the modified byte, advance the line
    logic clr_wr;    // clear one byte of the frame store
    logic rsp_load;  // load the response register
  } lndr_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic     clr_done;
    logic     wrap_done;
    logic     cnt_zero;
    logic     cnt_last;
    lndr_op_e op;
  } lndr_sts_t;

endpackage

/* design/lndr_if.sv */
`timescale 1ns / 1ps

interface lndr_cmd_if;
  logic              valid;
  logic              ready;
  lndr_pkg::lndr_cmd_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lndr_rsp_if;
  logic              valid;
  logic              ready;
  lndr_pkg::lndr_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* design/monochrome_line_draw_framebuffer_core.sv */
`timescale 1ns / 1ps

// Channel   Dir  Modport  Payload
// cmd_i     in   sink     operation, start_x, start_y, end_x, end_y, pixel_mode
// rsp_o     out  source   pixel_value, pixels_drawn
//
// Before the work, the start point is wrapped into the screen by folding off whole
// screen widths or heights. Then a plot does one pixel, a read only reads its byte,
// and a line does as many pixels as its major-axis length.
// Every pixel is a read-modify-write on the single-port frame store.
// Reset: a clearing pass writes zero to all SCREEN_WIDTH * SCREEN_PAGES bytes, one per
// cycle; cmd_i.ready stays low until it ends.
// Stalls: a new command is taken while the previous response still waits; the
// engine holds before loading its own response until the old one is taken.

module monochrome_line_draw_framebuffer_core #(
  parameter int SCREEN_WIDTH = lndr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_PAGES = lndr_pkg::SCREEN_PAGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lndr_cmd_if.sink    cmd_i,
  lndr_rsp_if.source  rsp_o
);

  // Command and status between sequencer and datapath
  lndr_pkg::lndr_ctl_t ctl;
  lndr_pkg::lndr_sts_t sts;

  // Sequencer: clearing pass, wrap, read/write per pixel, response
  lndr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  // Datapath: line geometry, Bresenham stepping, frame store, response register
  lndr_datapath #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_PAGES (SCREEN_PAGES)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .cmd_i  (cmd_i.payload),
    .sts_o  (sts),
    .rsp_o  (rsp_o.payload)
  );

`ifndef SYNTHESIS
  // One command at a time: after a transaction the engine is busy
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> !cmd_i.ready)
    else $error("command taken while engine busy");

  // No command is taken during the clearing pass
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.clr_wr |-> !cmd_i.ready)
    else $error("command ready during clearing pass");

  // A response is never overwritten before it is taken
  a_rsp_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.rsp_load |-> (!rsp_o.valid || rsp_o.ready))
    else $error("response overwritten");

  // Every pixel write follows the read of its byte
  a_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.pix_wr |-> $past(ctl.pix_rd))
    else $error("pixel write without preceding read");
`endif

endmodule

/* design/lndr_ctrl.sv */
`timescale 1ns / 1ps

module lndr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  input  lndr_pkg::lndr_sts_t sts_i,
  output lndr_pkg::lndr_ctl_t ctl_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRAP,
    S_READ,
    S_WRITE,
    S_DONE
  } state_e;

  state_e state_q;
  logic   rsp_valid_q;
  logic   rsp_valid_d;
  logic   rsp_free;

  assign rsp_free    = !rsp_valid_q || rsp_ready_i;
  assign cmd_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    ctl_o          = '0;
    ctl_o.load     = (state_q == S_IDLE) && cmd_valid_i;
    ctl_o.wrap     = (state_q == S_WRAP);
    ctl_o.pix_rd   = (state_q == S_READ);
    ctl_o.pix_wr   = (state_q == S_WRITE);
    ctl_o.clr_wr   = (state_q == S_CLEAR);
    ctl_o.rsp_load = (state_q == S_DONE) && rsp_free;
  end

  // drop the response once taken; a new load overrides
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
    if (ctl_o.rsp_load) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
      case (state_q)
        S_CLEAR: begin
          if (sts_i.clr_done) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid_i) begin
            state_q <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (sts_i.wrap_done) begin
            case (sts_i.op)
              lndr_pkg::OP_PLOT: state_q <= S_READ;
              lndr_pkg::OP_READ: state_q <= S_READ;
              lndr_pkg::OP_LINE: state_q <= sts_i.cnt_zero ? S_DONE : S_READ;
              default:           state_q <= S_DONE;
            endcase
          end
        end
        S_READ: begin
          state_q <= (sts_i.op == lndr_pkg::OP_READ) ? S_DONE : S_WRITE;
        end
        S_WRITE: begin
          if (sts_i.op == lndr_pkg::OP_LINE && !sts_i.cnt_last) begin
            state_q <= S_READ;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/lndr_datapath.sv */
`timescale 1ns / 1ps

module lndr_datapath #(
  parameter int SCREEN_WIDTH = lndr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_PAGES = lndr_pkg::SCREEN_PAGES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lndr_pkg::lndr_ctl_t ctl_i,
  input  lndr_pkg::lndr_cmd_t cmd_i,
  output lndr_pkg::lndr_sts_t sts_o,
  output lndr_pkg::lndr_rsp_t rsp_o
);

  localparam int Rows   = SCREEN_PAGES * 8;
  localparam int Depth  = SCREEN_WIDTH * SCREEN_PAGES;
  localparam int AddrW  = $clog2(Depth);
  localparam int ColW   = ($clog2(SCREEN_WIDTH) > lndr_pkg::X_W) ?
                          $clog2(SCREEN_WIDTH) : lndr_pkg::X_W;
  localparam int RowW   = ($clog2(Rows) > lndr_pkg::Y_W) ? $clog2(Rows) : lndr_pkg::Y_W;
  localparam int XW     = lndr_pkg::X_W;
  localparam int YW     = lndr_pkg::Y_W;
  localparam int CW     = lndr_pkg::COUNT_W;
  localparam int ErrW   = CW + 3;

  // Frame store and its read register
  logic [7:0]       frame_q [Depth];
  logic [7:0]       rdata_q;
  logic [AddrW-1:0] clr_q;

  // Command and line state
  lndr_pkg::lndr_op_e   op_q;
  lndr_pkg::lndr_mode_e mode_q;
  logic [ColW-1:0]      col_q;
  logic [RowW-1:0]      row_q;
  logic                 steep_q;
  logic                 minor_up_q;
  logic [CW-1:0]        major_q;
  logic [CW-1:0]        minor_q;
  logic [CW-1:0]        cnt_q;
  logic signed [ErrW-1:0] err_q;
  lndr_pkg::lndr_rsp_t  rsp_q;

  // Geometry of the incoming command
  logic [XW-1:0] adx;
  logic [YW-1:0] ady;
  logic          steep, rev, use_end, minor_up, is_line;
  logic [XW-1:0] near_x, far_x;
  logic [YW-1:0] near_y, far_y;
  logic [CW-1:0] major, minor;

  always_comb begin
    adx     = (cmd_i.start_x >= cmd_i.end_x) ? cmd_i.start_x - cmd_i.end_x
                                             : cmd_i.end_x - cmd_i.start_x;
    ady     = (cmd_i.start_y >= cmd_i.end_y) ? cmd_i.start_y - cmd_i.end_y
                                             : cmd_i.end_y - cmd_i.start_y;
    steep   = XW'(ady) > adx;
    rev     = steep ? (cmd_i.start_y > cmd_i.end_y) : (cmd_i.start_x > cmd_i.end_x);
    is_line = (lndr_pkg::lndr_op_e'(cmd_i.operation) == lndr_pkg::OP_LINE);
    use_end = is_line && rev;
    near_x  = use_end ? cmd_i.end_x : cmd_i.start_x;
    near_y  = use_end ? cmd_i.end_y : cmd_i.start_y;
    far_x   = use_end ? cmd_i.start_x : cmd_i.end_x;
    far_y   = use_end ? cmd_i.start_y : cmd_i.end_y;
    minor_up = steep ? (far_x > near_x) : (far_y > near_y);
    major   = steep ? CW'(ady) : CW'(adx);
    minor   = steep ? CW'(adx) : CW'(ady);
  end

  // Byte address and bit of the current point
  logic [AddrW-1:0] addr;
  logic [2:0]       bit_sel;
  logic [7:0]       bit_mask;
  logic [7:0]       wdata;

  assign addr     = AddrW'(32'(row_q >> 3) * 32'(SCREEN_WIDTH) + 32'(col_q));
  assign bit_sel  = row_q[2:0];
  assign bit_mask = 8'b1 << bit_sel;

  always_comb begin
    case (mode_q)
      lndr_pkg::MODE_SET:    wdata = rdata_q | bit_mask;
      lndr_pkg::MODE_CLEAR:  wdata = rdata_q & ~bit_mask;
      lndr_pkg::MODE_INVERT: wdata = rdata_q ^ bit_mask;
      default:               wdata = rdata_q;
    endcase
  end

  // Wrap of the start point and stepping along the line
  logic            col_big, row_big;
  logic [ColW-1:0] col_inc, col_dec;
  logic [RowW-1:0] row_inc, row_dec;
  logic signed [ErrW-1:0] err_sum;
  logic            move_minor;
  logic            advance;

  assign col_big = {1'b0, col_q} >= (ColW + 1)'(SCREEN_WIDTH);
  assign row_big = {1'b0, row_q} >= (RowW + 1)'(Rows);
  assign col_inc = (col_q == ColW'(SCREEN_WIDTH - 1)) ? '0 : col_q + 1'b1;
  assign col_dec = (col_q == '0) ? ColW'(SCREEN_WIDTH - 1) : col_q - 1'b1;
  assign row_inc = (row_q == RowW'(Rows - 1)) ? '0 : row_q + 1'b1;
  assign row_dec = (row_q == '0) ? RowW'(Rows - 1) : row_q - 1'b1;

  assign err_sum    = err_q + $signed({3'b000, minor_q});
  assign move_minor = (err_sum <<< 1) >= $signed({3'b000, major_q});
  assign advance    = ctl_i.pix_wr && (op_q == lndr_pkg::OP_LINE);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q       <= lndr_pkg::lndr_op_e'(cmd_i.operation);
      mode_q     <= lndr_pkg::lndr_mode_e'(cmd_i.pixel_mode);
      col_q      <= ColW'(near_x);
      row_q      <= RowW'(near_y);
      steep_q    <= steep;
      minor_up_q <= minor_up;
      major_q    <= major;
      minor_q    <= minor;
      cnt_q      <= major;
      err_q      <= '0;
    end else if (ctl_i.wrap) begin
      if (col_big) begin
        col_q <= col_q - ColW'(SCREEN_WIDTH);
      end
      if (row_big) begin
        row_q <= row_q - RowW'(Rows);
      end
    end else if (advance) begin
      cnt_q <= cnt_q - 1'b1;
      err_q <= move_minor ? err_sum - $signed({3'b000, major_q}) : err_sum;
      if (steep_q) begin
        row_q <= row_inc;
        if (move_minor) begin
          col_q <= minor_up_q ? col_inc : col_dec;
        end
      end else begin
        col_q <= col_inc;
        if (move_minor) begin
          row_q <= minor_up_q ? row_inc : row_dec;
        end
      end
    end
  end

  // Response register
  always_ff @(posedge clk_i) begin
    if (ctl_i.rsp_load) begin
      rsp_q.pixel_value <= (op_q == lndr_pkg::OP_READ) ? rdata_q[bit_sel] : 1'b0;
      case (op_q)
        lndr_pkg::OP_PLOT: rsp_q.pixels_drawn <= CW'(1);
        lndr_pkg::OP_LINE: rsp_q.pixels_drawn <= major_q;
        default:           rsp_q.pixels_drawn <= '0;
      endcase
    end
  end

  // Frame store
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_wr) begin
      frame_q[clr_q] <= 8'h00;
    end else if (ctl_i.pix_wr) begin
      frame_q[addr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.pix_rd) begin
      rdata_q <= frame_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctl_i.clr_wr) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign sts_o.clr_done  = (clr_q == AddrW'(Depth - 1));
  assign sts_o.wrap_done = !col_big && !row_big;
  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.cnt_last  = (cnt_q == CW'(1));
  assign sts_o.op        = op_q;
  assign rsp_o           = rsp_q;

endmodule
